[rtl/core/fire_heat_deposit_and_diffuse_unit_macros.svh]
// assertion macros for the heat deposit and diffuse unit
// used by the port checker, no other dependencies
`ifndef FIRE_HEAT_DEPOSIT_AND_DIFFUSE_UNIT_MACROS_SVH
`define FIRE_HEAT_DEPOSIT_AND_DIFFUSE_UNIT_MACROS_SVH

// same-cycle implication
`define FHDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fhdd same-cycle check failed");

// next-cycle implication
`define FHDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fhdd next-cycle check failed");

`endif

[rtl/core/fhdd_pkg.sv]
// shared constants, codes and controller/datapath interface structs
// for the heat deposit and diffuse unit; no dependencies
package fhdd_pkg;

  localparam int unsigned MAX_WIDTH     = 64;
  localparam int unsigned MAX_HEIGHT    = 32;
  localparam int unsigned STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned MIN_SWEEP_DIM = 3;

  localparam int unsigned WIDTH_W  = 7;
  localparam int unsigned HEIGHT_W = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned X_W      = 6;
  localparam int unsigned Y_W      = 5;
  localparam int unsigned HEAT_W   = 8;
  localparam int unsigned ACC_W    = HEAT_W + 2;
  localparam int unsigned PROD_W   = Y_W + WIDTH_W;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_DEPOSIT = 2'd1,
    MODE_SWEEP   = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ADDR_CLR    = 3'd0,
    ADDR_ITEM   = 3'd1,
    ADDR_LEFT   = 3'd2,
    ADDR_RIGHT  = 3'd3,
    ADDR_UP     = 3'd4,
    ADDR_DOWN   = 3'd5,
    ADDR_CENTER = 3'd6
  } addr_sel_e;

  typedef enum logic [1:0] {
    WR_ZERO = 2'd0,
    WR_MAX  = 2'd1,
    WR_DIFF = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic      load_item;
    logic      rd_en;
    logic      wr_en;
    addr_sel_e addr_sel;
    wr_sel_e   wr_sel;
    acc_op_e   acc_op;
    logic      clr_step;
    logic      sweep_init;
    logic      sweep_step;
    logic      res_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  in_frame;
    logic  sweep_ok;
    logic  sweep_last;
    logic  clr_last;
  } dp_status_t;

endpackage

[rtl/core/fhdd_datapath.sv]
// datapath: config registers, heat store memory, address generation,
// sweep and clear counters, neighbor accumulator, result register; uses fhdd_pkg
module fhdd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  fhdd_pkg::reg_idx_e             cfg_idx_i,
  input  logic [fhdd_pkg::CFG_W-1:0]     cfg_data_i,
  input  fhdd_pkg::mode_e                mode_i,
  input  logic [fhdd_pkg::X_W-1:0]       cell_x_i,
  input  logic [fhdd_pkg::Y_W-1:0]       cell_y_i,
  input  logic [fhdd_pkg::HEAT_W-1:0]    point_heat_i,
  input  fhdd_pkg::dp_cmd_t              cmd_i,
  output fhdd_pkg::dp_status_t           status_o,
  output logic [fhdd_pkg::HEAT_W-1:0]    cell_heat_o,
  output logic                           landed_o
);
  import fhdd_pkg::*;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ADDR_W-1:0]   w_ext;

  mode_e               mode_q;
  logic [HEAT_W-1:0]   heat_q;
  logic [ADDR_W-1:0]   idx_q;
  logic [ADDR_W-1:0]   idx_d;
  logic                in_frame_q;
  logic                in_frame_d;
  logic [PROD_W-1:0]   row_base;

  logic [X_W-1:0]      sx_q;
  logic [Y_W-1:0]      sy_q;
  logic [ADDR_W-1:0]   ctr_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                row_end;

  logic [ADDR_W-1:0]   addr;
  logic [HEAT_W-1:0]   wdata;
  logic [HEAT_W-1:0]   rdata_q;
  logic [HEAT_W-1:0]   mem [STORE_DEPTH];

  logic [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]    sum;
  logic [HEAT_W-1:0]   quarter;
  logic [HEAT_W-1:0]   diff_val;

  logic [HEAT_W-1:0]   cell_heat_q;
  logic                landed_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(MAX_WIDTH);
      height_q <= HEIGHT_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_q;
  assign w_ext = ADDR_W'(w_eff);

  // item capture
  assign in_frame_d = ({1'b0, cell_x_i} < w_eff) && ({1'b0, cell_y_i} < h_eff);
  assign row_base   = PROD_W'(cell_y_i) * PROD_W'(w_eff);
  assign idx_d      = ADDR_W'(row_base + PROD_W'(cell_x_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q     <= mode_i;
      heat_q     <= point_heat_i;
      idx_q      <= idx_d;
      in_frame_q <= in_frame_d;
    end
  end

  // sweep position and clear counter
  assign row_end = ({1'b0, sx_q} == (w_eff - WIDTH_W'(2)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q      <= '0;
      sy_q      <= '0;
      ctr_q     <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cmd_i.sweep_init) begin
        sx_q  <= X_W'(1);
        sy_q  <= Y_W'(1);
        ctr_q <= w_ext + ADDR_W'(1);
      end else if (cmd_i.sweep_step) begin
        if (row_end) begin
          sx_q  <= X_W'(1);
          sy_q  <= sy_q + Y_W'(1);
          // step over right border and left border of next row
          ctr_q <= ctr_q + ADDR_W'(3);
        end else begin
          sx_q  <= sx_q + X_W'(1);
          ctr_q <= ctr_q + ADDR_W'(1);
        end
      end
    end
  end

  // address and write data
  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CLR:    addr = clr_cnt_q;
      ADDR_ITEM:   addr = idx_q;
      ADDR_LEFT:   addr = ctr_q - ADDR_W'(1);
      ADDR_RIGHT:  addr = ctr_q + ADDR_W'(1);
      ADDR_UP:     addr = ctr_q - w_ext;
      ADDR_DOWN:   addr = ctr_q + w_ext;
      ADDR_CENTER: addr = ctr_q;
      default:     addr = clr_cnt_q;
    endcase
  end

  assign sum      = acc_q + ACC_W'(rdata_q);
  assign quarter  = sum[ACC_W-1:2];
  assign diff_val = (quarter == '0) ? '0 : quarter - HEAT_W'(1);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_ZERO: wdata = '0;
      WR_MAX:  wdata = (heat_q > rdata_q) ? heat_q : rdata_q;
      WR_DIFF: wdata = diff_val;
      default: wdata = '0;
    endcase
  end

  // heat store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr];
    end
  end

  // neighbor sum
  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(rdata_q);
      ACC_ADD:  acc_q <= sum;
      default:  acc_q <= acc_q;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      cell_heat_q <= (mode_q == MODE_READ && in_frame_q) ? rdata_q : '0;
      landed_q    <= in_frame_q && (mode_q == MODE_DEPOSIT || mode_q == MODE_READ);
    end
  end

  assign cell_heat_o = cell_heat_q;
  assign landed_o    = landed_q;

  assign status_o.mode       = mode_q;
  assign status_o.in_frame   = in_frame_q;
  assign status_o.sweep_ok   = (w_eff >= WIDTH_W'(MIN_SWEEP_DIM))
                             && (h_eff >= HEIGHT_W'(MIN_SWEEP_DIM));
  assign status_o.sweep_last = row_end && ({1'b0, sy_q} == (h_eff - HEIGHT_W'(2)));
  assign status_o.clr_last   = (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1));

endmodule

[rtl/core/fhdd_ctrl.sv]
// controller state machine: store clearing, item decode, deposit/read
// access, sweep sequencing and output handshake; uses fhdd_pkg
module fhdd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fhdd_pkg::dp_cmd_t    cmd_o,
  input  fhdd_pkg::dp_status_t status_i
);
  import fhdd_pkg::*;

  typedef enum logic [11:0] {
    ST_INIT    = 12'b0000_0000_0001,
    ST_IDLE    = 12'b0000_0000_0010,
    ST_DECODE  = 12'b0000_0000_0100,
    ST_CLEAR   = 12'b0000_0000_1000,
    ST_ITEM_RD = 12'b0000_0001_0000,
    ST_ITEM_WR = 12'b0000_0010_0000,
    ST_SW_L    = 12'b0000_0100_0000,
    ST_SW_R    = 12'b0000_1000_0000,
    ST_SW_U    = 12'b0001_0000_0000,
    ST_SW_D    = 12'b0010_0000_0000,
    ST_SW_W    = 12'b0100_0000_0000,
    ST_RESULT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    state_d          = state_q;
    cmd_o.load_item  = 1'b0;
    cmd_o.rd_en      = 1'b0;
    cmd_o.wr_en      = 1'b0;
    cmd_o.addr_sel   = ADDR_CLR;
    cmd_o.wr_sel     = WR_ZERO;
    cmd_o.acc_op     = ACC_HOLD;
    cmd_o.clr_step   = 1'b0;
    cmd_o.sweep_init = 1'b0;
    cmd_o.sweep_step = 1'b0;
    cmd_o.res_load   = 1'b0;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESULT;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.mode)
          MODE_CLEAR: state_d = ST_CLEAR;
          MODE_SWEEP: begin
            if (status_i.sweep_ok) begin
              cmd_o.sweep_init = 1'b1;
              state_d          = ST_SW_L;
            end else begin
              state_d = ST_RESULT;
            end
          end
          default: state_d = ST_ITEM_RD;
        endcase
      end
      ST_ITEM_RD: begin
        cmd_o.addr_sel = ADDR_ITEM;
        cmd_o.rd_en    = 1'b1;
        state_d        = ST_ITEM_WR;
      end
      ST_ITEM_WR: begin
        cmd_o.addr_sel = ADDR_ITEM;
        cmd_o.wr_sel   = WR_MAX;
        cmd_o.wr_en    = (status_i.mode == MODE_DEPOSIT) && status_i.in_frame;
        state_d        = ST_RESULT;
      end
      ST_SW_L: begin
        cmd_o.addr_sel = ADDR_LEFT;
        cmd_o.rd_en    = 1'b1;
        state_d        = ST_SW_R;
      end
      ST_SW_R: begin
        cmd_o.addr_sel = ADDR_RIGHT;
        cmd_o.rd_en    = 1'b1;
        cmd_o.acc_op   = ACC_LOAD;
        state_d        = ST_SW_U;
      end
      ST_SW_U: begin
        cmd_o.addr_sel = ADDR_UP;
        cmd_o.rd_en    = 1'b1;
        cmd_o.acc_op   = ACC_ADD;
        state_d        = ST_SW_D;
      end
      ST_SW_D: begin
        cmd_o.addr_sel = ADDR_DOWN;
        cmd_o.rd_en    = 1'b1;
        cmd_o.acc_op   = ACC_ADD;
        state_d        = ST_SW_W;
      end
      ST_SW_W: begin
        cmd_o.addr_sel   = ADDR_CENTER;
        cmd_o.wr_sel     = WR_DIFF;
        cmd_o.wr_en      = 1'b1;
        cmd_o.sweep_step = 1'b1;
        state_d          = status_i.sweep_last ? ST_RESULT : ST_SW_L;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/fire_heat_deposit_and_diffuse_unit.sv]
// top level of the heat deposit and diffuse unit
// instantiates fhdd_ctrl and fhdd_datapath; uses fhdd_pkg
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+----------------------------------
//   input   | in        | in_valid_i / in_stall_o | mode, cell_x, cell_y, point_heat
//   output  | out       | out_valid_o/out_stall_i | cell_heat, landed
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// deposit and read: one store read, plus one write for a deposit that lands in the frame
// sweep: four store reads and one write per interior cell
// clear: one store write per cell of the whole store
// after reset a clearing pass over the whole store runs with the input stalled
// one word in flight; the result register lets the next word in while it waits
module fire_heat_deposit_and_diffuse_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fhdd_pkg::mode_e               mode_i,
  input  logic [fhdd_pkg::X_W-1:0]      cell_x_i,
  input  logic [fhdd_pkg::Y_W-1:0]      cell_y_i,
  input  logic [fhdd_pkg::HEAT_W-1:0]   point_heat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fhdd_pkg::HEAT_W-1:0]   cell_heat_o,
  output logic                          landed_o,
  input  logic                          cfg_we_i,
  input  fhdd_pkg::reg_idx_e            cfg_idx_i,
  input  logic [fhdd_pkg::CFG_W-1:0]    cfg_data_i
);
  import fhdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fhdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fhdd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .point_heat_i (point_heat_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .cell_heat_o  (cell_heat_o),
    .landed_o     (landed_o)
  );

endmodule

[rtl/core/fhdd_checker.sv]
// port-level checker for the heat deposit and diffuse unit and its bind
// uses fhdd_pkg and fire_heat_deposit_and_diffuse_unit_macros.svh
`include "fire_heat_deposit_and_diffuse_unit_macros.svh"

module fhdd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [fhdd_pkg::HEAT_W-1:0] cell_heat_o,
  input logic                        landed_o
);
  import fhdd_pkg::*;

  // a word held back by stall stays valid
  `FHDD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result word does not change
  `FHDD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(cell_heat_o) && $stable(landed_o))

  // a word that did not land carries no heat
  `FHDD_ASSERT_IMPLY(a_no_heat, clk_i, rst_ni, out_valid_o && !landed_o, cell_heat_o == '0)

  // one word at a time: accept is followed by a stalled cycle
  `FHDD_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind fire_heat_deposit_and_diffuse_unit fhdd_checker u_checker (.*);

[dv/fire_heat_deposit_and_diffuse_unit_tb.sv]
// testbench for fire_heat_deposit_and_diffuse_unit: directed table then random words,
// every result checked in order against the row's typed word, if the table gives one,
// else a behavioral heat frame predictor; depends on fhdd_pkg and the unit's rtl only
module fire_heat_deposit_and_diffuse_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fhdd_pkg::*;

  typedef struct packed {
    logic [HEAT_W-1:0] cell_heat;
    logic              landed;
  } heat_word_t;

  typedef struct packed {
    logic              frame_row;
    logic [CFG_W-1:0]  width_val;
    logic [CFG_W-1:0]  height_val;
    mode_e             mode;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [HEAT_W-1:0] heat;
    logic              typed;
    logic [HEAT_W-1:0] heat_typed;
    logic              landed_typed;
  } plan_row_t;

  localparam int PLAN_LEN     = 32;
  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_LEN  = 34;
  localparam int SETTLE_TICKS = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  mode_e             mode_i;
  logic [X_W-1:0]    cell_x_i;
  logic [Y_W-1:0]    cell_y_i;
  logic [HEAT_W-1:0] point_heat_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [HEAT_W-1:0] cell_heat_o;
  logic              landed_o;
  logic              cfg_we_i;
  reg_idx_e          cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  logic [HEAT_W-1:0] heat_cells [STORE_DEPTH];
  logic [WIDTH_W-1:0]  frame_w_reg;
  logic [HEIGHT_W-1:0] frame_h_reg;
  heat_word_t        pending_heat_q [$];
  heat_word_t        due_word;
  int                fail_count = 0;
  int                send_gap_pct;
  int                out_stall_pct;

  //   cfg  w    h    mode          x   y   heat typed heat landed
  plan_row_t plan_rows [PLAN_LEN] = '{
    '{0,   0,   0,  MODE_READ,     0,  0,   0, 1,   0, 1},
    '{0,   0,   0,  MODE_READ,    63, 31,   0, 1,   0, 1},
    '{0,   0,   0,  MODE_DEPOSIT, 63, 31, 255, 1,   0, 1},
    '{0,   0,   0,  MODE_READ,    63, 31,   0, 1, 255, 1},
    '{0,   0,   0,  MODE_DEPOSIT, 63, 31,  17, 1,   0, 1},
    '{0,   0,   0,  MODE_READ,    63, 31,   0, 1, 255, 1},
    '{0,   0,   0,  MODE_DEPOSIT, 10,  5, 200, 0,   0, 0},
    '{0,   0,   0,  MODE_SWEEP,    0,  0,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,    10,  5,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_READ,    11,  5,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_CLEAR,    0,  0,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,    63, 31,   0, 1,   0, 1},
    '{1, 127,  63,  MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_DEPOSIT, 63, 31, 170, 1,   0, 1},
    '{0,   0,   0,  MODE_READ,    63, 31,   0, 1, 170, 1},
    '{1,   5,   4,  MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_DEPOSIT,  5,  0,   9, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,     0,  4,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_DEPOSIT,  2,  1, 100, 0,   0, 0},
    '{0,   0,   0,  MODE_SWEEP,    0,  0,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,     1,  1,   0, 0,   0, 0},
    '{1,   2,   4,  MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_SWEEP,    0,  0,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,     1,  1,   0, 0,   0, 0},
    '{1,   0,  32,  MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_DEPOSIT,  0,  0,   5, 1,   0, 0},
    '{1,  64,   0,  MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_READ,     0,  0,   0, 1,   0, 0},
    '{1,   3, 'h43, MODE_CLEAR,    0,  0,   0, 0,   0, 0},
    '{0,   0,   0,  MODE_DEPOSIT,  1,  0,  85, 0,   0, 0},
    '{0,   0,   0,  MODE_SWEEP,    0,  0,   0, 1,   0, 0},
    '{0,   0,   0,  MODE_READ,     1,  1,   0, 0,   0, 0}
  };

  fire_heat_deposit_and_diffuse_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .point_heat_i(point_heat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_heat_o (cell_heat_o),
    .landed_o    (landed_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic int frame_cols();
    return (frame_w_reg > MAX_WIDTH) ? MAX_WIDTH : frame_w_reg;
  endfunction

  function automatic int frame_rows();
    return (frame_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : frame_h_reg;
  endfunction

  function automatic heat_word_t apply_heat_word(mode_e mode, logic [X_W-1:0] x,
                                                 logic [Y_W-1:0] y, logic [HEAT_W-1:0] heat);
    int cols, rows, idx, sum, cx, cy;
    heat_word_t r;
    cols = frame_cols();
    rows = frame_rows();
    r    = '0;
    idx  = y * cols + x;
    case (mode)
      MODE_CLEAR: begin
        foreach (heat_cells[i]) heat_cells[i] = '0;
      end
      MODE_DEPOSIT: begin
        if (x < cols && y < rows) begin
          if (heat > heat_cells[idx]) heat_cells[idx] = heat;
          r.landed = 1'b1;
        end
      end
      MODE_SWEEP: begin
        // in place, so left and upper neighbors already hold new values
        if (cols >= MIN_SWEEP_DIM && rows >= MIN_SWEEP_DIM) begin
          for (cy = 1; cy < rows - 1; cy++) begin
            for (cx = 1; cx < cols - 1; cx++) begin
              idx = cy * cols + cx;
              sum = heat_cells[idx-1] + heat_cells[idx+1] + heat_cells[idx-cols] +
                    heat_cells[idx+cols];
              sum = sum >> 2;
              heat_cells[idx] = (sum > 0) ? HEAT_W'(sum - 1) : '0;
            end
          end
        end
      end
      default: begin
        if (x < cols && y < rows) begin
          r.cell_heat = heat_cells[idx];
          r.landed    = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_word(mode_e mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                           logic [HEAT_W-1:0] heat, logic typed, heat_word_t typed_word);
    heat_word_t due;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    cell_x_i     <= x;
    cell_y_i     <= y;
    point_heat_i <= heat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due = apply_heat_word(mode, x, y, heat);
    pending_heat_q = {pending_heat_q, (typed ? typed_word : due)};
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_heat_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    frame_w_reg = w;
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    frame_h_reg = h[HEIGHT_W-1:0];
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_heat_q.size() == 0) begin
        $display("%0t: unexpected word cell_heat %0d landed %0d", $time, cell_heat_o,
                 landed_o);
        fail_count++;
      end else begin
        due_word = pending_heat_q.pop_front();
        if (cell_heat_o !== due_word.cell_heat) begin
          $display("%0t: cell_heat expected %0d actual %0d", $time, due_word.cell_heat,
                   cell_heat_o);
          fail_count++;
        end
        if (landed_o !== due_word.landed) begin
          $display("%0t: landed expected %0d actual %0d", $time, due_word.landed, landed_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int seg, pick, cols, rows;
    mode_e mode;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_CLEAR;
    cell_x_i     = '0;
    cell_y_i     = '0;
    point_heat_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_FRAME_WIDTH;
    cfg_data_i   = '0;
    frame_w_reg  = 7'd64;
    frame_h_reg  = 6'd32;
    foreach (heat_cells[i]) heat_cells[i] = '0;
    send_gap_pct  = 38;
    out_stall_pct = 54;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].frame_row) begin
        drain_words();
        set_frame(plan_rows[i].width_val, plan_rows[i].height_val);
      end else begin
        send_word(plan_rows[i].mode, plan_rows[i].x, plan_rows[i].y, plan_rows[i].heat,
                  plan_rows[i].typed, '{plan_rows[i].heat_typed, plan_rows[i].landed_typed});
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_gap_pct  = 54;
        out_stall_pct = 38;
      end
      if (seg == 8) begin
        send_gap_pct  = 0;
        out_stall_pct = 0;
      end
      drain_words();
      if (seg == 5) set_frame(7'd64, 7'd32);
      else if (seg == 9) set_frame(CFG_W'($urandom_range(127, 65)),
                                   CFG_W'($urandom_range(63, 33)));
      else if (seg == 11) set_frame(CFG_W'($urandom_range(64, 3)),
                                    CFG_W'($urandom_range(6, 3)));
      else set_frame(CFG_W'($urandom_range(12)), CFG_W'($urandom_range(12)));
      cols = frame_cols();
      rows = frame_rows();
      repeat (SEGMENT_LEN) begin
        pick = $urandom_range(99);
        if (pick < 4) mode = MODE_CLEAR;
        else if (pick < 16) mode = MODE_SWEEP;
        else if (pick < 58) mode = MODE_DEPOSIT;
        else mode = MODE_READ;
        if ($urandom_range(99) < 85 && cols > 0 && rows > 0) begin
          x = X_W'($urandom_range(cols - 1));
          y = Y_W'($urandom_range(rows - 1));
        end else begin
          x = X_W'($urandom_range(63));
          y = Y_W'($urandom_range(31));
        end
        send_word(mode, x, y, HEAT_W'($urandom_range(255)), 1'b0, '0);
      end
    end

    drain_words();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (fail_count == 0 && pending_heat_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[fire_heat_deposit_and_diffuse_unit.f]
+incdir+rtl/core
rtl/core/fhdd_pkg.sv
rtl/core/fhdd_datapath.sv
rtl/core/fhdd_ctrl.sv
rtl/core/fire_heat_deposit_and_diffuse_unit.sv
rtl/core/fhdd_checker.sv
dv/fire_heat_deposit_and_diffuse_unit_tb.sv
